/* rtl/binomial_tree_option_pricer_top_defines.svh */
`ifndef BINOMIAL_TREE_OPTION_PRICER_TOP_DEFINES_SVH
`define BINOMIAL_TREE_OPTION_PRICER_TOP_DEFINES_SVH

// antecedent implies consequent in the next cycle, ignored while in reset
`define BTOP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// same, also checked across reset
`define BTOP_ASSERT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/btop_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package btop_pkg;

   localparam int VAL_W         = 48;
   localparam int FAC_W         = 32;
   localparam int FRAC_W        = 28;
   localparam int NSTEP_W       = 7;
   localparam int CSR_IDX_W     = 3;
   localparam int MAX_STEPS_DEF = 64;
   localparam int PROB_W        = FRAC_W + 1;

   localparam logic [VAL_W-1:0]  VAL_MAX = {VAL_W{1'b1}};
   localparam logic [PROB_W-1:0] ONE_Q28 = PROB_W'(1) << FRAC_W;

   // divider: dividend is value << 28, a few quotient bits per cycle
   localparam int DVD_W       = VAL_W + FRAC_W;
   localparam int DIV_BITS    = 4;
   localparam int DIV_CYCLES  = DVD_W / DIV_BITS;
   localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

   localparam logic [CSR_IDX_W-1:0] CSR_UP_FACTOR    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN_FACTOR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_GROWTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_DISCNT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_STEPS    = 3'd4;

   localparam logic [FAC_W-1:0]   UP_FACTOR_RST    = 32'd322122547;
   localparam logic [FAC_W-1:0]   DOWN_FACTOR_RST  = 32'd223696213;
   localparam logic [FAC_W-1:0]   STEP_GROWTH_RST  = 32'd273858215;
   localparam logic [FAC_W-1:0]   STEP_DISCNT_RST  = 32'd263120076;
   localparam logic [NSTEP_W-1:0] NUM_STEPS_RST    = 7'd3;

   typedef struct packed {
      logic [VAL_W-1:0] spot_price;
      logic [VAL_W-1:0] strike_price;
      logic             is_call;
      logic             is_american;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] option_value;
      logic             bad_factors;
      logic             saturated;
   } rsp_type;

   typedef struct packed {
      logic [FAC_W-1:0]   up_factor;
      logic [FAC_W-1:0]   down_factor;
      logic [FAC_W-1:0]   step_growth;
      logic [FAC_W-1:0]   step_discount;
      logic [NSTEP_W-1:0] num_steps;
   } cfg_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PROB,
      ST_PROB_WAIT,
      ST_TERM,
      ST_TERM_WAIT,
      ST_INIT_WR,
      ST_UP_MUL,
      ST_UP_MUL_WAIT,
      ST_UP_DIV,
      ST_UP_DIV_WAIT,
      ST_LVL,
      ST_LVL_WAIT,
      ST_NODE_RD,
      ST_NODE_CAP,
      ST_MUL_P,
      ST_MUL_P_WAIT,
      ST_MUL_Q,
      ST_MUL_Q_WAIT,
      ST_MUL_D,
      ST_MUL_D_WAIT,
      ST_DIV_A,
      ST_DIV_A_WAIT,
      ST_NODE_WR,
      ST_DONE
   } state_type;

   function automatic logic [VAL_W-1:0] exercise_value(input logic [VAL_W-1:0] s,
                                                       input logic [VAL_W-1:0] k,
                                                       input logic call);
      logic [VAL_W-1:0] r;
      if (call) begin
         r = (s > k) ? s - k : '0;
      end else begin
         r = (k > s) ? k - s : '0;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/binomial_tree_option_pricer_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel   ports                           direction  payload
// request   req_valid req_stall req_data    in         spot, strike, call, american
// response  rsp_valid rsp_stall rsp_data    out        option value, bad factors, saturated
// csr       csr_valid csr_ready csr_index   in         32-bit register write data
//
// one option at a time; N = num_steps capped at MAX_STEPS
// per node cost is set by the shared two-stage multiplier and, for american options, the 4-bit-per-cycle divider
// synchronous active-high reset clears control; node memories hold no reset value
// a finished result waits in the response register while the next option is taken in
module binomial_tree_option_pricer_top
   import btop_pkg::*;
#(
   parameter int MAX_STEPS = MAX_STEPS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [FAC_W-1:0]     csr_wdata
);

   cfg_type cfg_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    core_idle;
   logic    core_res_valid;
   rsp_type core_res;
   logic    out_free;
   logic    start;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !core_idle;
   assign start     = req_valid && core_idle;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.up_factor     <= UP_FACTOR_RST;
         cfg_ff.down_factor   <= DOWN_FACTOR_RST;
         cfg_ff.step_growth   <= STEP_GROWTH_RST;
         cfg_ff.step_discount <= STEP_DISCNT_RST;
         cfg_ff.num_steps     <= NUM_STEPS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_UP_FACTOR:   cfg_ff.up_factor     <= csr_wdata;
            CSR_DOWN_FACTOR: cfg_ff.down_factor   <= csr_wdata;
            CSR_STEP_GROWTH: cfg_ff.step_growth   <= csr_wdata;
            CSR_STEP_DISCNT: cfg_ff.step_discount <= csr_wdata;
            CSR_NUM_STEPS:   cfg_ff.num_steps     <= csr_wdata[NSTEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_res_valid && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (core_res_valid && out_free) begin
         rsp_data_ff <= core_res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   btop_core #(
      .MAX_STEPS (MAX_STEPS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_data),
      .cfg       (cfg_ff),
      .out_free  (out_free),
      .idle      (core_idle),
      .res_valid (core_res_valid),
      .res       (core_res)
   );

endmodule
`default_nettype wire

/* rtl/btop_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
module btop_mul
   import btop_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [VAL_W-1:0] x,
   input  wire logic [FAC_W-1:0] f,
   output logic                  done,
   output logic [VAL_W-1:0]      res,
   output logic                  sat
);

   localparam int HALF_W = VAL_W / 2;
   localparam int PROD_W = HALF_W + FAC_W;

   logic              stg_vld_ff;
   logic              done_ff;
   logic [PROD_W-1:0] hi_prod_ff;
   logic [PROD_W-1:0] lo_prod_ff;
   logic [VAL_W-1:0]  res_ff;
   logic              sat_ff;
   logic [PROD_W:0]   low_in;
   logic [PROD_W-3:0] sum_in;

   // floor(x * f / 2^28) from two 24x32 partial products
   always_comb begin
      low_in = (PROD_W + 1)'({hi_prod_ff[3:0], {HALF_W{1'b0}}}) + (PROD_W + 1)'(lo_prod_ff);
      sum_in = (PROD_W - 2)'(hi_prod_ff[PROD_W-1:4]) + (PROD_W - 2)'(low_in[PROD_W:FRAC_W]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         stg_vld_ff <= start;
         done_ff    <= stg_vld_ff;
      end
      if (start) begin
         hi_prod_ff <= PROD_W'(x[VAL_W-1:HALF_W]) * PROD_W'(f);
         lo_prod_ff <= PROD_W'(x[HALF_W-1:0]) * PROD_W'(f);
      end
      if (stg_vld_ff) begin
         sat_ff <= |sum_in[PROD_W-3:VAL_W];
         res_ff <= (|sum_in[PROD_W-3:VAL_W]) ? VAL_MAX : sum_in[VAL_W-1:0];
      end
   end

   assign done = done_ff;
   assign res  = res_ff;
   assign sat  = sat_ff;

endmodule
`default_nettype wire

/* rtl/btop_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module btop_div
   import btop_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [VAL_W-1:0] x,
   input  wire logic [FAC_W-1:0] f,
   output logic                  done,
   output logic [VAL_W-1:0]      res,
   output logic                  sat
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DVD_W-1:0]     dvd_ff;
   logic [FAC_W-1:0]     rem_ff;
   logic [VAL_W-1:0]     quot_ff;
   logic                 ovf_ff;
   logic [FAC_W-1:0]     f_ff;
   logic [VAL_W-1:0]     res_ff;
   logic                 sat_ff;

   logic [DVD_W-1:0]     dvd_in;
   logic [FAC_W-1:0]     rem_in;
   logic [VAL_W-1:0]     quot_in;
   logic                 ovf_in;
   logic [FAC_W:0]       trial;
   logic                 qbit;

   // restoring division, DIV_BITS quotient bits per cycle; bits above 48 flag overflow
   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      ovf_in  = ovf_ff;
      trial   = '0;
      qbit    = 1'b0;
      for (int b = 0; b < DIV_BITS; b++) begin
         trial  = {rem_in, dvd_in[DVD_W-1]};
         dvd_in = {dvd_in[DVD_W-2:0], 1'b0};
         ovf_in = ovf_in | quot_in[VAL_W-1];
         if (trial >= {1'b0, f_ff}) begin
            trial = trial - {1'b0, f_ff};
            qbit  = 1'b1;
         end else begin
            qbit  = 1'b0;
         end
         rem_in  = trial[FAC_W-1:0];
         quot_in = {quot_in[VAL_W-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if (f == '0) begin
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
            end
         end else if (busy_ff && cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         cnt_ff  <= '0;
         dvd_ff  <= {x, {FRAC_W{1'b0}}};
         rem_ff  <= '0;
         quot_ff <= '0;
         ovf_ff  <= 1'b0;
         f_ff    <= f;
         // division by zero clips at once
         res_ff  <= VAL_MAX;
         sat_ff  <= 1'b1;
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff + DIV_CNT_W'(1);
         dvd_ff  <= dvd_in;
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         ovf_ff  <= ovf_in;
         res_ff  <= ovf_in ? VAL_MAX : quot_in;
         sat_ff  <= ovf_in;
      end
   end

   assign done = done_ff;
   assign res  = res_ff;
   assign sat  = sat_ff;

endmodule
`default_nettype wire

/* rtl/btop_core.sv */
`timescale 1ns / 1ps
`default_nettype none
module btop_core
   import btop_pkg::*;
#(
   parameter int MAX_STEPS = MAX_STEPS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req,
   input  wire cfg_type cfg,
   input  wire logic    out_free,
   output logic         idle,
   output logic         res_valid,
   output rsp_type      res
);

   localparam int IDX_W = $clog2(MAX_STEPS + 1);
   localparam int DEPTH = MAX_STEPS + 1;

   state_type state_ff, state_in;

   logic [VAL_W-1:0]  asset_mem [DEPTH];
   logic [VAL_W-1:0]  opt_mem   [DEPTH];
   logic [VAL_W-1:0]  asset_rdata_ff;
   logic [VAL_W-1:0]  opt_rdata_ff;

   logic              asset_we;
   logic [IDX_W-1:0]  asset_waddr;
   logic [VAL_W-1:0]  asset_wdata;
   logic [IDX_W-1:0]  asset_raddr;
   logic              opt_we;
   logic [IDX_W-1:0]  opt_waddr;
   logic [VAL_W-1:0]  opt_wdata;
   logic [IDX_W-1:0]  opt_raddr;

   logic [VAL_W-1:0]  k_ff;
   logic              call_ff;
   logic              amer_ff;
   logic              bad_ff;
   logic              sat_ff;
   logic [IDX_W-1:0]  n_ff;
   logic [IDX_W-1:0]  cnt_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  lvl_ff;
   logic [IDX_W-1:0]  j_ff;
   logic [PROB_W-1:0] p_ff;
   logic [VAL_W-1:0]  v_ff;
   logic [VAL_W-1:0]  opt_lo_ff;
   logic [VAL_W-1:0]  opt_hi_ff;
   logic [VAL_W-1:0]  asset_cur_ff;
   logic [VAL_W:0]    acc_ff;
   logic [VAL_W-1:0]  last_ff;

   logic [IDX_W-1:0]  n_in;
   logic [PROB_W-1:0] q_prob;
   logic [VAL_W-1:0]  e_val;
   logic [VAL_W-1:0]  ex_init;
   logic [VAL_W-1:0]  ex_node;
   logic [VAL_W-1:0]  node_val;
   logic              last_node;

   logic              mul_start, mul_done, mul_sat;
   logic [VAL_W-1:0]  mul_x, mul_res;
   logic [FAC_W-1:0]  mul_f;
   logic              div_start, div_done, div_sat;
   logic [VAL_W-1:0]  div_x, div_res;
   logic [FAC_W-1:0]  div_f;

   btop_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .x     (mul_x),
      .f     (mul_f),
      .done  (mul_done),
      .res   (mul_res),
      .sat   (mul_sat)
   );

   btop_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .x     (div_x),
      .f     (div_f),
      .done  (div_done),
      .res   (div_res),
      .sat   (div_sat)
   );

   always_comb begin
      if (32'(cfg.num_steps) > 32'(MAX_STEPS)) begin
         n_in = IDX_W'(MAX_STEPS);
      end else begin
         n_in = IDX_W'(cfg.num_steps);
      end
      q_prob    = ONE_Q28 - p_ff;
      e_val     = acc_ff[VAL_W] ? VAL_MAX : acc_ff[VAL_W-1:0];
      ex_init   = exercise_value(v_ff, k_ff, call_ff);
      ex_node   = exercise_value(asset_cur_ff, k_ff, call_ff);
      node_val  = (amer_ff && ex_node > v_ff) ? ex_node : v_ff;
      last_node = (j_ff + IDX_W'(1)) == lvl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      mul_start   = 1'b0;
      mul_x       = v_ff;
      mul_f       = cfg.down_factor;
      div_start   = 1'b0;
      div_x       = v_ff;
      div_f       = cfg.down_factor;
      asset_we    = 1'b0;
      asset_waddr = idx_ff;
      asset_wdata = v_ff;
      asset_raddr = j_ff;
      opt_we      = 1'b0;
      opt_waddr   = idx_ff;
      opt_wdata   = ex_init;
      opt_raddr   = j_ff + IDX_W'(1);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_PROB;
            end
         end
         ST_PROB: begin
            if (cfg.step_growth <= cfg.down_factor || cfg.step_growth >= cfg.up_factor) begin
               state_in = ST_TERM;
            end else begin
               div_start = 1'b1;
               div_x     = VAL_W'(cfg.step_growth - cfg.down_factor);
               div_f     = cfg.up_factor - cfg.down_factor;
               state_in  = ST_PROB_WAIT;
            end
         end
         ST_PROB_WAIT: begin
            if (div_done) begin
               state_in = ST_TERM;
            end
         end
         ST_TERM: begin
            if (cnt_ff == n_ff) begin
               state_in = ST_INIT_WR;
            end else begin
               mul_start = 1'b1;
               state_in  = ST_TERM_WAIT;
            end
         end
         ST_TERM_WAIT: begin
            if (mul_done) begin
               state_in = ST_TERM;
            end
         end
         ST_INIT_WR: begin
            asset_we = 1'b1;
            opt_we   = 1'b1;
            if (idx_ff != n_ff) begin
               state_in = ST_UP_MUL;
            end else if (n_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_LVL;
            end
         end
         ST_UP_MUL: begin
            mul_start = 1'b1;
            mul_f     = cfg.up_factor;
            state_in  = ST_UP_MUL_WAIT;
         end
         ST_UP_MUL_WAIT: begin
            if (mul_done) begin
               state_in = ST_UP_DIV;
            end
         end
         ST_UP_DIV: begin
            div_start = 1'b1;
            state_in  = ST_UP_DIV_WAIT;
         end
         ST_UP_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_INIT_WR;
            end
         end
         ST_LVL: begin
            opt_raddr = '0;
            state_in  = ST_LVL_WAIT;
         end
         ST_LVL_WAIT: begin
            state_in = ST_NODE_RD;
         end
         ST_NODE_RD: begin
            // old value of node j+1 and asset price of node j
            state_in = ST_NODE_CAP;
         end
         ST_NODE_CAP: begin
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            mul_start = 1'b1;
            mul_x     = opt_hi_ff;
            mul_f     = FAC_W'(p_ff);
            state_in  = ST_MUL_P_WAIT;
         end
         ST_MUL_P_WAIT: begin
            if (mul_done) begin
               state_in = ST_MUL_Q;
            end
         end
         ST_MUL_Q: begin
            mul_start = 1'b1;
            mul_x     = opt_lo_ff;
            mul_f     = FAC_W'(q_prob);
            state_in  = ST_MUL_Q_WAIT;
         end
         ST_MUL_Q_WAIT: begin
            if (mul_done) begin
               state_in = ST_MUL_D;
            end
         end
         ST_MUL_D: begin
            mul_start = 1'b1;
            mul_x     = e_val;
            mul_f     = cfg.step_discount;
            state_in  = ST_MUL_D_WAIT;
         end
         ST_MUL_D_WAIT: begin
            if (mul_done) begin
               state_in = amer_ff ? ST_DIV_A : ST_NODE_WR;
            end
         end
         ST_DIV_A: begin
            div_start = 1'b1;
            div_x     = asset_cur_ff;
            state_in  = ST_DIV_A_WAIT;
         end
         ST_DIV_A_WAIT: begin
            if (div_done) begin
               state_in = ST_NODE_WR;
            end
         end
         ST_NODE_WR: begin
            opt_we      = 1'b1;
            opt_waddr   = j_ff;
            opt_wdata   = node_val;
            asset_we    = amer_ff;
            asset_waddr = j_ff;
            asset_wdata = asset_cur_ff;
            if (!last_node) begin
               state_in = ST_NODE_RD;
            end else if (lvl_ff == IDX_W'(1)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_LVL;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (asset_we) begin
         asset_mem[asset_waddr] <= asset_wdata;
      end
      asset_rdata_ff <= asset_mem[asset_raddr];
      if (opt_we) begin
         opt_mem[opt_waddr] <= opt_wdata;
      end
      opt_rdata_ff <= opt_mem[opt_raddr];
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            k_ff    <= req.strike_price;
            call_ff <= req.is_call;
            amer_ff <= req.is_american;
            v_ff    <= req.spot_price;
            n_ff    <= n_in;
            cnt_ff  <= '0;
            idx_ff  <= '0;
            sat_ff  <= 1'b0;
            bad_ff  <= !(cfg.step_growth > cfg.down_factor &&
                         cfg.step_growth < cfg.up_factor);
         end
         ST_PROB: begin
            p_ff <= (cfg.step_growth <= cfg.down_factor) ? '0 : ONE_Q28;
         end
         ST_PROB_WAIT: begin
            if (div_done) begin
               p_ff <= div_res[PROB_W-1:0];
            end
         end
         ST_TERM_WAIT: begin
            if (mul_done) begin
               v_ff   <= mul_res;
               cnt_ff <= cnt_ff + IDX_W'(1);
               sat_ff <= sat_ff | mul_sat;
            end
         end
         ST_INIT_WR: begin
            last_ff <= ex_init;
            idx_ff  <= idx_ff + IDX_W'(1);
            lvl_ff  <= n_ff;
         end
         ST_UP_MUL_WAIT: begin
            if (mul_done) begin
               v_ff   <= mul_res;
               sat_ff <= sat_ff | mul_sat;
            end
         end
         ST_UP_DIV_WAIT: begin
            if (div_done) begin
               v_ff   <= div_res;
               sat_ff <= sat_ff | div_sat;
            end
         end
         ST_LVL: begin
            j_ff <= '0;
         end
         ST_LVL_WAIT: begin
            opt_lo_ff <= opt_rdata_ff;
         end
         ST_NODE_CAP: begin
            opt_hi_ff    <= opt_rdata_ff;
            asset_cur_ff <= asset_rdata_ff;
         end
         ST_MUL_P_WAIT: begin
            if (mul_done) begin
               acc_ff <= {1'b0, mul_res};
               sat_ff <= sat_ff | mul_sat;
            end
         end
         ST_MUL_Q_WAIT: begin
            if (mul_done) begin
               acc_ff <= acc_ff + {1'b0, mul_res};
               sat_ff <= sat_ff | mul_sat;
            end
         end
         ST_MUL_D: begin
            sat_ff <= sat_ff | acc_ff[VAL_W];
         end
         ST_MUL_D_WAIT: begin
            if (mul_done) begin
               v_ff   <= mul_res;
               sat_ff <= sat_ff | mul_sat;
            end
         end
         ST_DIV_A_WAIT: begin
            if (div_done) begin
               asset_cur_ff <= div_res;
               sat_ff       <= sat_ff | div_sat;
            end
         end
         ST_NODE_WR: begin
            last_ff   <= node_val;
            opt_lo_ff <= opt_hi_ff;
            if (last_node) begin
               lvl_ff <= lvl_ff - IDX_W'(1);
            end else begin
               j_ff <= j_ff + IDX_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign idle             = state_ff == ST_IDLE;
   assign res_valid        = state_ff == ST_DONE;
   assign res.option_value = last_ff;
   assign res.bad_factors  = bad_ff;
   assign res.saturated    = sat_ff;

endmodule
`default_nettype wire

/* rtl/btop_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "binomial_tree_option_pricer_top_defines.svh"
module btop_checker
   import btop_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // a held response stays up
   `BTOP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "response dropped while stalled")
   // a held response keeps its payload
   `BTOP_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_data), "response changed while stalled")
   // nothing comes out right after reset
   `BTOP_ASSERT_RST(a_rst_quiet, reset, !rsp_valid, "response valid after reset")
   // pricing is still under way after a transaction is taken, so a new transaction blocks the next
   `BTOP_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "second transaction taken while pricing")

endmodule

bind binomial_tree_option_pricer_top btop_checker u_btop_checker (.*);
`default_nettype wire
